### hw/rtl/astar_pkg.sv
// shared types and constants for the a-star path search block
// no dependencies; imported by astar_heur, astar_shortest_path_search, its checker and testbench
package astar_pkg;

  localparam int NumNodes  = 256;
  localparam int NumEdges  = 1024;
  localparam int MaxDegree = 16;
  localparam int PathCap   = 255;

  typedef enum logic [1:0] {
    ModeNodeWr = 2'd0,
    ModeEdgeWr = 2'd1,
    ModeSearch = 2'd2,
    ModePathRd = 2'd3
  } mode_e;

  typedef enum logic {
    CfgStart  = 1'b0,
    CfgTarget = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  node_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        occupied;
    logic [9:0]  first_edge;
    logic [4:0]  edge_count;
    logic [9:0]  edge_index;
    logic [7:0]  edge_source;
    logic [7:0]  edge_dest;
    logic [23:0] edge_weight;
    logic [7:0]  path_step;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  hop_count;
    logic [31:0] total_cost;
    logic [7:0]  step_source;
    logic [7:0]  step_dest;
    logic [23:0] step_weight;
    logic        step_valid;
  } rsp_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        blk;
    logic [9:0]  base;
    logic [4:0]  deg;
  } node_t;

  typedef struct packed {
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [23:0] cost;
  } edge_t;

  typedef struct packed {
    logic [31:0] f;
    logic [7:0]  node;
  } open_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dx;
    logic [15:0] dy;
  } heur_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] h;
  } heur_rsp_t;

endpackage

### hw/rtl/astar_heur.sv
// euclidean distance unit: one shared 16x16 multiplier, then a bit-serial square root
// depends on astar_pkg
module astar_heur (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  astar_pkg::heur_req_t  req_i,
  output astar_pkg::heur_rsp_t  rsp_o
);
  import astar_pkg::*;

  typedef enum logic [1:0] {HIdle, HMulX, HMulY, HRoot} hstate_e;

  hstate_e     state_q;
  logic [15:0] op_q, dy_q;
  logic [31:0] sum_q;
  logic [49:0] v_q, r_q, b_q;
  logic        done_q;
  logic [31:0] prod;
  logic [32:0] sq_sum;
  logic [49:0] trial;

  // shared multiplier squares one difference per cycle
  assign prod   = {16'h0000, op_q} * {16'h0000, op_q};
  assign sq_sum = {1'b0, sum_q} + {1'b0, prod};
  assign trial  = r_q + b_q;

  // sequencer: square dx, square dy, then one root bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        HIdle: begin
          if (req_i.start) begin
            op_q    <= req_i.dx;
            dy_q    <= req_i.dy;
            state_q <= HMulX;
          end
        end
        HMulX: begin
          sum_q   <= prod;
          op_q    <= dy_q;
          state_q <= HMulY;
        end
        HMulY: begin
          v_q     <= {1'b0, sq_sum, 16'h0000};
          r_q     <= '0;
          b_q     <= 50'd1 << 48;
          state_q <= HRoot;
        end
        HRoot: begin
          if (v_q >= trial) begin
            v_q <= v_q - trial;
            r_q <= (r_q >> 1) + b_q;
          end else begin
            r_q <= r_q >> 1;
          end
          b_q <= b_q >> 2;
          if (b_q[0]) begin
            done_q  <= 1'b1;
            state_q <= HIdle;
          end
        end
        default: state_q <= HIdle;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.h    = r_q[31:0];

endmodule

### hw/rtl/astar_shortest_path_search.sv
// a-star search top level: tables, open list, sequencer and result register
// depends on astar_pkg and astar_heur
//
// Requests in mode 0 and 1 write one node or edge entry and give no response.
// A search (mode 2) takes nodes from the open list and, per usable edge examined,
// waits on the square-root unit that gives the distance estimate (25 root
// bits after dx and dy are squared); open-list entries are moved one at a
// time when a node is inserted or re-placed, since the sorted open list lives
// in a memory with one read and one write port; then the path is walked back
// edge by edge. No reset sweep is needed: search state is tracked by per-node
// flag bits cleared at the start of each search.
module astar_shortest_path_search (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  astar_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output astar_pkg::rsp_t  out_rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [7:0]       cfg_wdata_i
);
  import astar_pkg::*;

  typedef enum logic [4:0] {
    SIdle, SInit, STgt, SPop, SPop2, SNode, SEdge, SEdge2, SEdge3, SHwait,
    SRemScan, SRemChk, SRemSh, SRemSh2, SInsScan, SInsChk,
    SPath0, SPw, SPw2, SPw3, SFin, SRd0, SRd1, SRd2, SResp
  } state_e;

  state_e              state_q;
  logic [7:0]          start_q, target_q, step_q;
  logic [15:0]         tx_q, ty_q;
  logic [NumNodes-1:0] seen_q, closed_q;
  logic [7:0]          head_q, plen_q;
  logic [8:0]          len_q, idx_q;
  logic                found_q;
  logic [31:0]         fcost_q, gn_q, gnew_q, f_q;
  logic [9:0]          base_q, e_q;
  logic [4:0]          deg_q, k_q;
  logic [7:0]          d_q, cur_q;
  logic [23:0]         c_q;
  rsp_t                res_q, out_q;
  logic                out_valid_q;

  // memories and their registered read data
  node_t node_mem [NumNodes];
  edge_t edge_mem [NumEdges];
  logic [31:0] g_mem [NumNodes];
  logic [9:0]  front_mem [NumNodes];
  open_t open_mem [NumNodes];
  logic [9:0]  path_mem [NumNodes];

  node_t       node_rd;
  edge_t       edge_rd;
  logic [31:0] g_rd;
  logic [9:0]  front_rd, path_rd;
  open_t       open_rd;

  logic [7:0]  node_ra, g_ra, g_wa, front_wa, open_ra, open_wa, path_ra;
  logic [9:0]  edge_ra;
  logic        g_we, front_we, open_we, path_we;
  logic [31:0] g_wd;
  open_t       open_wd, ins_new;

  heur_req_t   heur_req;
  heur_rsp_t   heur_rsp;

  logic        in_acc, skip_nb, is_new, is_better, ins_here;
  logic [10:0] ebig;
  logic [32:0] gsum, fsum;
  logic [31:0] gsat, fsat;
  logic [15:0] dx, dy;
  logic [7:0]  off;
  logic [9:0]  idx_nxt;

  assign in_acc  = in_valid_i && (state_q == SIdle);
  assign ebig    = {1'b0, base_q} + {6'b0, k_q};
  assign gsum    = {1'b0, gn_q} + {9'b0, c_q};
  assign gsat    = gsum[32] ? 32'hFFFF_FFFF : gsum[31:0];
  assign fsum    = {1'b0, gnew_q} + {1'b0, heur_rsp.h};
  assign fsat    = fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];
  assign skip_nb = node_rd.blk && (d_q != target_q);
  assign is_new    = !seen_q[d_q];
  assign is_better = (gnew_q < g_rd) && !closed_q[d_q];
  assign ins_new   = '{f: f_q, node: d_q};
  assign ins_here  = !(ins_new.f < open_rd.f);
  assign idx_nxt   = {1'b0, idx_q} + 10'd1;
  assign dx = (tx_q > node_rd.x) ? tx_q - node_rd.x : node_rd.x - tx_q;
  assign dy = (ty_q > node_rd.y) ? ty_q - node_rd.y : node_rd.y - ty_q;

  // distance estimate starts once the neighbour is known to be usable
  assign heur_req.start = (state_q == SEdge3) && !skip_nb;
  assign heur_req.dx    = dx;
  assign heur_req.dy    = dy;

  astar_heur u_heur (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (heur_req),
    .rsp_o  (heur_rsp)
  );

  // read address selection
  always_comb begin
    unique case (state_q)
      SInit:   node_ra = target_q;
      SPop2:   node_ra = open_rd.node;
      SEdge2:  node_ra = edge_rd.dst;
      default: node_ra = d_q;
    endcase
    unique case (state_q)
      SEdge:   edge_ra = ebig[9:0];
      SPw2:    edge_ra = front_rd;
      SRd1:    edge_ra = path_rd;
      default: edge_ra = e_q;
    endcase
    g_ra = (state_q == SPop2) ? open_rd.node : d_q;
    unique case (state_q)
      SRemSh:   off = idx_nxt[7:0];
      SInsScan: off = idx_q[7:0] - 8'd1;
      SRemScan: off = idx_q[7:0];
      default:  off = 8'd0;
    endcase
    open_ra = head_q + off;
    path_ra = plen_q - 8'd1 - step_q;
  end

  // write port selection
  always_comb begin
    g_we     = 1'b0;
    g_wa     = d_q;
    g_wd     = gnew_q;
    front_we = 1'b0;
    front_wa = d_q;
    open_we  = 1'b0;
    open_wa  = head_q + idx_q[7:0];
    open_wd  = ins_new;
    path_we  = (state_q == SPw2);
    unique case (state_q)
      STgt: begin
        g_we    = 1'b1;
        g_wa    = start_q;
        g_wd    = '0;
        open_we = 1'b1;
        open_wa = head_q;
        open_wd = '{f: 32'd0, node: start_q};
      end
      SHwait: begin
        g_we     = heur_rsp.done && (is_new || is_better);
        front_we = g_we;
      end
      SRemSh2: begin
        open_we = 1'b1;
        open_wd = open_rd;
      end
      SInsScan: open_we = (idx_q == 9'd0);
      SInsChk: begin
        open_we = 1'b1;
        open_wd = ins_here ? ins_new : open_rd;
      end
      default: ;
    endcase
  end

  // node and edge tables
  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.mode == ModeNodeWr) begin
      node_mem[in_req_i.node_id] <= '{x: in_req_i.pos_x, y: in_req_i.pos_y,
                                      blk: in_req_i.occupied, base: in_req_i.first_edge,
                                      deg: in_req_i.edge_count};
    end
    node_rd <= node_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.mode == ModeEdgeWr) begin
      edge_mem[in_req_i.edge_index] <= '{src: in_req_i.edge_source,
                                         dst: in_req_i.edge_dest,
                                         cost: in_req_i.edge_weight};
    end
    edge_rd <= edge_mem[edge_ra];
  end

  // search state memories
  always_ff @(posedge clk_i) begin
    if (g_we) g_mem[g_wa] <= g_wd;
    g_rd <= g_mem[g_ra];
  end

  always_ff @(posedge clk_i) begin
    if (front_we) front_mem[front_wa] <= e_q;
    front_rd <= front_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    open_rd <= open_mem[open_ra];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) path_mem[plen_q] <= front_rd;
    path_rd <= path_mem[path_ra];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      start_q     <= '0;
      target_q    <= '0;
      seen_q      <= '0;
      closed_q    <= '0;
      head_q      <= '0;
      len_q       <= '0;
      plen_q      <= '0;
      found_q     <= 1'b0;
      fcost_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // configuration
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgStart:  start_q  <= cfg_wdata_i;
          CfgTarget: target_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != SResp) out_valid_q <= 1'b0;

      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            step_q <= in_req_i.path_step;
            unique case (in_req_i.mode)
              ModeSearch: state_q <= SInit;
              ModePathRd: state_q <= SRd0;
              default:    state_q <= SIdle;
            endcase
          end
        end
        SInit: begin
          seen_q   <= '0;
          closed_q <= '0;
          head_q   <= '0;
          len_q    <= '0;
          plen_q   <= '0;
          found_q  <= 1'b0;
          fcost_q  <= '0;
          state_q  <= STgt;
        end
        STgt: begin
          tx_q            <= node_rd.x;
          ty_q            <= node_rd.y;
          seen_q[start_q] <= 1'b1;
          len_q           <= 9'd1;
          state_q         <= SPop;
        end
        SPop: state_q <= (len_q == 9'd0) ? SFin : SPop2;
        SPop2: begin
          cur_q                 <= open_rd.node;
          head_q                <= head_q + 8'd1;
          len_q                 <= len_q - 9'd1;
          closed_q[open_rd.node] <= 1'b1;
          if (open_rd.node == target_q) begin
            found_q <= 1'b1;
            state_q <= SPath0;
          end else begin
            state_q <= SNode;
          end
        end
        SNode: begin
          gn_q    <= g_rd;
          base_q  <= node_rd.base;
          deg_q   <= (node_rd.deg > 5'(MaxDegree)) ? 5'(MaxDegree) : node_rd.deg;
          k_q     <= '0;
          state_q <= SEdge;
        end
        SEdge: begin
          if (k_q == deg_q) begin
            state_q <= SPop;
          end else if (ebig[10]) begin
            k_q <= k_q + 5'd1;
          end else begin
            e_q     <= ebig[9:0];
            state_q <= SEdge2;
          end
        end
        SEdge2: begin
          d_q     <= edge_rd.dst;
          c_q     <= edge_rd.cost;
          state_q <= SEdge3;
        end
        SEdge3: begin
          if (skip_nb) begin
            k_q     <= k_q + 5'd1;
            state_q <= SEdge;
          end else begin
            gnew_q  <= gsat;
            state_q <= SHwait;
          end
        end
        SHwait: begin
          if (heur_rsp.done) begin
            f_q <= fsat;
            priority if (is_new) begin
              seen_q[d_q] <= 1'b1;
              if (len_q[8]) begin
                k_q     <= k_q + 5'd1;
                state_q <= SEdge;
              end else begin
                idx_q   <= len_q;
                state_q <= SInsScan;
              end
            end else if (is_better) begin
              idx_q       <= '0;
              state_q     <= SRemScan;
            end else begin
              k_q     <= k_q + 5'd1;
              state_q <= SEdge;
            end
          end
        end
        // take the re-costed node out of the open list
        SRemScan: begin
          if (idx_q == len_q) begin
            if (len_q[8]) begin
              k_q     <= k_q + 5'd1;
              state_q <= SEdge;
            end else begin
              state_q <= SInsScan;
            end
          end else begin
            state_q <= SRemChk;
          end
        end
        SRemChk: begin
          if (open_rd.node == d_q) begin
            state_q <= SRemSh;
          end else begin
            idx_q   <= idx_nxt[8:0];
            state_q <= SRemScan;
          end
        end
        SRemSh: begin
          if (idx_nxt >= {1'b0, len_q}) begin
            len_q   <= len_q - 9'd1;
            idx_q   <= len_q - 9'd1;
            state_q <= SInsScan;
          end else begin
            state_q <= SRemSh2;
          end
        end
        SRemSh2: begin
          idx_q   <= idx_nxt[8:0];
          state_q <= SRemSh;
        end
        // sorted insert from the tail, equal costs stay behind
        SInsScan: begin
          if (idx_q == 9'd0) begin
            len_q   <= len_q + 9'd1;
            k_q     <= k_q + 5'd1;
            state_q <= SEdge;
          end else begin
            state_q <= SInsChk;
          end
        end
        SInsChk: begin
          if (ins_here) begin
            len_q   <= len_q + 9'd1;
            k_q     <= k_q + 5'd1;
            state_q <= SEdge;
          end else begin
            idx_q   <= idx_q - 9'd1;
            state_q <= SInsScan;
          end
        end
        // walk the tree edges back from the target
        SPath0: begin
          fcost_q <= g_rd;
          cur_q   <= target_q;
          state_q <= SPw;
        end
        SPw: begin
          if (cur_q == start_q || !closed_q[cur_q] || plen_q == 8'(PathCap)) begin
            state_q <= SFin;
          end else begin
            state_q <= SPw2;
          end
        end
        SPw2: begin
          plen_q  <= plen_q + 8'd1;
          state_q <= SPw3;
        end
        SPw3: begin
          cur_q   <= edge_rd.src;
          state_q <= SPw;
        end
        SFin: begin
          res_q   <= '{found: found_q, hop_count: plen_q, total_cost: fcost_q,
                       step_source: 8'd0, step_dest: 8'd0, step_weight: 24'd0,
                       step_valid: 1'b0};
          state_q <= SResp;
        end
        // path step read back
        SRd0: begin
          res_q <= '{found: found_q, hop_count: plen_q, total_cost: fcost_q,
                     step_source: 8'd0, step_dest: 8'd0, step_weight: 24'd0,
                     step_valid: 1'b0};
          state_q <= (step_q < plen_q) ? SRd1 : SResp;
        end
        SRd1: state_q <= SRd2;
        SRd2: begin
          res_q.step_source <= edge_rd.src;
          res_q.step_dest   <= edge_rd.dst;
          res_q.step_weight <= edge_rd.cost;
          res_q.step_valid  <= 1'b1;
          state_q           <= SResp;
        end
        SResp: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= 9'(NumNodes)) else $error("open list overflow");

  a_path_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plen_q != 8'd0) |-> found_q) else $error("path held without a found target");

  a_heur_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heur_rsp.done |-> (state_q == SHwait)) else $error("distance result not awaited");

  a_search_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && in_valid_i && in_req_i.mode == ModeSearch) |=> (state_q == SInit))
    else $error("search request not started");
`endif

endmodule

### tb/sv/astar_shortest_path_search_checker.sv
// checker for the a-star path search block: predicts every response and compares
// depends on astar_pkg; watches the request, response and register ports
module astar_shortest_path_search_checker
  import astar_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_stall_i,
  input  req_t  in_req_i,
  input  logic  out_valid_i,
  input  logic  out_stall_i,
  input  rsp_t  out_rsp_i,
  input  logic  cfg_we_i,
  input  logic  cfg_idx_i,
  input  logic  [7:0] cfg_wdata_i,
  output int    pending_o,
  output int    checked_o,
  output int    errors_o
);

  localparam int ExpDepth = 16;

  // mirrored tables and registers
  node_t       node_tab [NumNodes];
  edge_t       edge_tab [NumEdges];
  int          start_id, goal_id;

  // search state
  logic [31:0] g_val [NumNodes];
  logic [31:0] f_val [NumNodes];
  int          front_e [NumNodes];
  int          tree_e [NumNodes];
  bit          seen [NumNodes];
  bit          closed [NumNodes];
  int          open_q [NumNodes];
  int          open_len = 0;
  int          route [PathCap];
  int          route_len = 0;
  bit          goal_hit = 0;
  logic [31:0] goal_cost = 0;

  // expected responses in arrival order
  rsp_t        exp_mem [ExpDepth];
  int          exp_rd = 0;
  int          exp_wr = 0;
  int          pending = 0;
  int          checked = 0;
  int          errors = 0;

  assign pending_o = pending;
  assign checked_o = checked;
  assign errors_o  = errors;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // euclidean distance estimate, 8 fraction bits
  function automatic logic [31:0] dist_est(input int a, input int b);
    logic [63:0] dx, dy, s, h;
    dx = node_tab[a].x > node_tab[b].x ? node_tab[a].x - node_tab[b].x
                                       : node_tab[b].x - node_tab[a].x;
    dy = node_tab[a].y > node_tab[b].y ? node_tab[a].y - node_tab[b].y
                                       : node_tab[b].y - node_tab[a].y;
    s = dx * dx + dy * dy;
    h = (s < (64'd1 << 48)) ? root64(s << 16) : (root64(s) << 8);
    return (h > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : h[31:0];
  endfunction

  function automatic void open_drop(input int p);
    for (int i = p; i < open_len - 1; i++) open_q[i] = open_q[i + 1];
    open_len--;
  endfunction

  // sorted insert, equal f keeps arrival order
  function automatic void open_add(input int n);
    int p;
    p = 0;
    if (open_len >= NumNodes) return;
    while (p < open_len && !(f_val[n] < f_val[open_q[p]])) p++;
    for (int i = open_len; i > p; i--) open_q[i] = open_q[i - 1];
    open_q[p] = n;
    open_len++;
  endfunction

  function automatic void find_route();
    int n, deg, e, d, p, cur;
    logic [31:0] g, fv;
    for (int i = 0; i < NumNodes; i++) begin
      g_val[i] = 0; f_val[i] = 0; front_e[i] = -1; tree_e[i] = -1;
      seen[i] = 0; closed[i] = 0;
    end
    open_len = 0; route_len = 0; goal_hit = 0; goal_cost = 0;
    seen[start_id] = 1;
    open_q[0] = start_id;
    open_len = 1;
    while (open_len > 0) begin
      n = open_q[0];
      open_drop(0);
      closed[n] = 1;
      tree_e[n] = front_e[n];
      if (n == goal_id) begin
        goal_hit = 1;
        break;
      end
      deg = (node_tab[n].deg > MaxDegree) ? MaxDegree : int'(node_tab[n].deg);
      for (int k = 0; k < deg; k++) begin
        e = int'(node_tab[n].base) + k;
        if (e >= NumEdges) continue;
        d = edge_tab[e].dst;
        if (node_tab[d].blk && d != goal_id) continue;
        g  = sat_sum(g_val[n], {8'd0, edge_tab[e].cost});
        fv = sat_sum(g, dist_est(goal_id, d));
        if (!seen[d]) begin
          seen[d] = 1; front_e[d] = e; g_val[d] = g; f_val[d] = fv;
          open_add(d);
        end else if (g < g_val[d] && !closed[d]) begin
          g_val[d] = g; f_val[d] = fv; front_e[d] = e;
          p = 0;
          while (p < open_len && open_q[p] != d) p++;
          if (p < open_len) open_drop(p);
          open_add(d);
        end
      end
    end
    // walk the tree back from the goal
    if (goal_hit) begin
      goal_cost = g_val[goal_id];
      cur = goal_id;
      while (cur != start_id && tree_e[cur] >= 0 && route_len < PathCap) begin
        e = tree_e[cur];
        route[route_len++] = e;
        cur = edge_tab[e].src;
      end
    end
  endfunction

  function automatic void predict(input req_t r);
    rsp_t x;
    int e;
    case (r.mode)
      ModeNodeWr: begin
        node_tab[r.node_id] = '{r.pos_x, r.pos_y, r.occupied, r.first_edge, r.edge_count};
      end
      ModeEdgeWr: begin
        edge_tab[r.edge_index] = '{r.edge_source, r.edge_dest, r.edge_weight};
      end
      default: begin
        if (r.mode == ModeSearch) find_route();
        x = '0;
        x.found = goal_hit;
        x.hop_count = route_len[7:0];
        x.total_cost = goal_cost;
        if (r.mode == ModePathRd && int'(r.path_step) < route_len) begin
          e = route[route_len - 1 - int'(r.path_step)];
          x.step_source = edge_tab[e].src;
          x.step_dest   = edge_tab[e].dst;
          x.step_weight = edge_tab[e].cost;
          x.step_valid  = 1'b1;
        end
        exp_mem[exp_wr] = x;
        exp_wr = (exp_wr + 1) % ExpDepth;
        pending++;
      end
    endcase
  endfunction

  // responses first, then the request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t w;
    if (!rst_ni) begin
      start_id = 0;
      goal_id  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending == 0) begin
          report("response with nothing expected");
        end else begin
          w = exp_mem[exp_rd];
          exp_rd = (exp_rd + 1) % ExpDepth;
          pending--;
          checked++;
          if (out_rsp_i.found != w.found)
            report($sformatf("found %0d, want %0d", out_rsp_i.found, w.found));
          if (out_rsp_i.hop_count != w.hop_count)
            report($sformatf("hop_count %0d, want %0d", out_rsp_i.hop_count, w.hop_count));
          if (out_rsp_i.total_cost != w.total_cost)
            report($sformatf("total_cost %h, want %h", out_rsp_i.total_cost, w.total_cost));
          if (out_rsp_i.step_source != w.step_source)
            report($sformatf("step_source %0d, want %0d", out_rsp_i.step_source,
                             w.step_source));
          if (out_rsp_i.step_dest != w.step_dest)
            report($sformatf("step_dest %0d, want %0d", out_rsp_i.step_dest, w.step_dest));
          if (out_rsp_i.step_weight != w.step_weight)
            report($sformatf("step_weight %h, want %h", out_rsp_i.step_weight,
                             w.step_weight));
          if (out_rsp_i.step_valid != w.step_valid)
            report($sformatf("step_valid %0d, want %0d", out_rsp_i.step_valid,
                             w.step_valid));
        end
      end
      if (in_valid_i && !in_stall_i) predict(in_req_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgStart) start_id = cfg_wdata_i;
        else goal_id = cfg_wdata_i;
      end
    end
  end

endmodule

### tb/sv/astar_shortest_path_search_tb.sv
// top of the a-star path search testbench: clock, reset, stimulus and verdict
// depends on astar_pkg, astar_shortest_path_search and its checker
module astar_shortest_path_search_tb;
  import astar_pkg::*;

  logic        clk_i, rst_ni;
  logic        in_valid, in_stall, out_valid, out_stall;
  req_t        in_req;
  rsp_t        out_rsp;
  logic        cfg_we, cfg_idx;
  logic [7:0]  cfg_wdata;
  int          pending, checked, errors;
  int          tx_pct, rx_pct;
  int          n_search, n_read, n_write;
  bit          hold_req, hold_done;
  int          hold_left;

  astar_shortest_path_search DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  astar_shortest_path_search_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .checked_o   (checked),
    .errors_o    (errors)
  );

  // clock
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  // request with random filler in the fields that the mode ignores
  function automatic req_t noise_req();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  // graph node: base at id*2, or a random group for node 255
  function automatic req_t node_req(input int id);
    req_t r;
    r = noise_req();
    r.mode = ModeNodeWr;
    r.node_id = 8'(id);
    r.occupied = ($urandom_range(0, 4) == 0);
    r.first_edge = (id == 255) ? 10'($urandom_range(0, 15) * 2) : 10'(id * 2);
    r.edge_count = 5'($urandom_range(0, 2));
    return r;
  endfunction

  function automatic req_t edge_req(input int slot);
    req_t r;
    r = noise_req();
    r.mode = ModeEdgeWr;
    r.edge_index = 10'(slot);
    r.edge_source = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'((slot % 32) / 2);
    r.edge_dest = ($urandom_range(0, 11) == 0) ? 8'd255 : 8'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: r.edge_weight = 24'hFF_FFFF;
      1: r.edge_weight = 24'd0;
      2, 3: r.edge_weight = 24'($urandom_range(0, 4095));
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_t cmd_req(input mode_e m, input int step);
    req_t r;
    r = noise_req();
    r.mode = m;
    if (step >= 0) r.path_step = 8'(step);
    return r;
  endfunction

  // one request through the handshake, after a random idle gap
  task automatic send(input req_t r);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < tx_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (in_stall);
    if (r.mode == ModeSearch) n_search++;
    else if (r.mode == ModePathRd) n_read++;
    else n_write++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_pair(input int s, input int t);
    wait_idle();
    cfg_we <= 1'b1; cfg_idx <= CfgStart; cfg_wdata <= 8'(s);
    @(posedge clk_i);
    cfg_idx <= CfgTarget; cfg_wdata <= 8'(t);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic search_and_read(input int s, input int t);
    set_pair(s, t);
    send(cmd_req(ModeSearch, -1));
    send(cmd_req(ModePathRd, 0));
    send(cmd_req(ModePathRd, 1));
    send(cmd_req(ModePathRd, 255));
  endtask

  function automatic int pick_node();
    return ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 15);
  endfunction

  initial begin
    req_t r;
    int   p;
    in_valid = 0; in_req = '0; out_stall = 0;
    cfg_we = 0; cfg_idx = CfgStart; cfg_wdata = 0;
    tx_pct = 0; rx_pct = 0;
    n_search = 0; n_read = 0; n_write = 0;
    hold_req = 0; hold_done = 0; hold_left = 0;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // load the graph: nodes 0..15 and 255, edge groups, clamp and overrun slots
    for (int i = 0; i < 16; i++) send(node_req(i));
    send(node_req(255));
    for (int i = 0; i < 48; i++) send(edge_req(i));
    for (int i = 1020; i < 1024; i++) send(edge_req(i));

    // directed: read before any search, degree clamp, table overrun, blocked goal
    send(cmd_req(ModePathRd, 0));
    r = node_req(15); r.first_edge = 10'd32; r.edge_count = 5'd31; send(r);
    r = node_req(14); r.first_edge = 10'd1020; r.edge_count = 5'd8; send(r);
    r = node_req(3);  r.occupied = 1; send(r);
    search_and_read(0, 15);
    search_and_read(5, 5);
    search_and_read(0, 3);
    search_and_read(255, 0);
    search_and_read(0, 255);
    search_and_read(15, 14);

    // random part in four idling phases
    for (int k = 0; k < 40; k++) begin
      case (k / 10)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 51; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 51; end
        default: begin tx_pct = 34; rx_pct = 34; end
      endcase
      if (k == 5) begin
        // long receiver hold-off while path reads pile up
        hold_req = 1;
        for (int j = 0; j < 10; j++) send(cmd_req(ModePathRd, $urandom_range(0, 4)));
      end
      p = $urandom_range(0, 99);
      if (p < 30) begin
        if ($urandom_range(0, 2) == 0) set_pair(pick_node(), pick_node());
        send(cmd_req(ModeSearch, -1));
      end else if (p < 65) begin
        send(cmd_req(ModePathRd, $urandom_range(0, 1) ? $urandom_range(0, 5)
                                                      : $urandom_range(0, 255)));
      end else if (p < 78) begin
        send(node_req(pick_node()));
      end else if (p < 90) begin
        send(edge_req($urandom_range(0, 47)));
      end else if (p < 95) begin
        r = noise_req(); r.mode = ModeNodeWr; r.node_id = 8'($urandom_range(16, 254));
        send(r);
      end else begin
        r = noise_req(); r.mode = ModeEdgeWr; r.edge_index = 10'($urandom_range(48, 1019));
        send(r);
      end
    end

    in_valid <= 1'b0;
    repeat (3) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d searches, %0d path reads and %0d table writes", n_search,
             n_read, n_write);
    $display("%0d responses compared, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("astar_shortest_path_search_tb passed");
    end else begin
      $display("astar_shortest_path_search_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("timeout waiting for the block");
    $display("astar_shortest_path_search_tb failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/astar_pkg.sv
hw/rtl/astar_heur.sv
hw/rtl/astar_shortest_path_search.sv
tb/sv/astar_shortest_path_search_checker.sv
tb/sv/astar_shortest_path_search_tb.sv
